/* rtl/core/tqs_pkg.sv */
`default_nettype none
// ============================================================================
// Timer queue scheduler package
// Shared field types, operation and result codes, register indexes and
// register reset values.
// ============================================================================
package tqs_pkg;

   localparam int TIME_W   = 40;
   localparam int IVL_W    = 24;
   localparam int CFG_W    = 16;
   localparam int HANDLE_W = 4;

   typedef logic [1:0]          func_type;
   typedef logic [2:0]          kind_type;
   typedef logic [1:0]          csr_index_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [IVL_W-1:0]    ivl_type;
   typedef logic [CFG_W-1:0]    cfg_type;
   typedef logic [HANDLE_W-1:0] handle_type;

   // operations
   localparam func_type FUNC_ADD     = 2'd0;
   localparam func_type FUNC_DELETE  = 2'd1;
   localparam func_type FUNC_ADVANCE = 2'd2;

   // result kinds
   localparam kind_type KIND_ADDED   = 3'd0;
   localparam kind_type KIND_FULL    = 3'd1;
   localparam kind_type KIND_FIRED   = 3'd2;
   localparam kind_type KIND_DELETED = 3'd3;
   localparam kind_type KIND_DONE    = 3'd4;

   // register indexes
   localparam csr_index_type CSR_CATCHUP  = 2'd0;
   localparam csr_index_type CSR_DEF_WAIT = 2'd1;
   localparam csr_index_type CSR_MIN_WAIT = 2'd2;

   // register reset values: one second, one second, ten milliseconds
   localparam cfg_type CATCHUP_RESET  = 16'd1000;
   localparam cfg_type DEF_WAIT_RESET = 16'd1000;
   localparam cfg_type MIN_WAIT_RESET = 16'd10;

endpackage
`default_nettype wire

/* rtl/core/tqs_ram.sv */
`default_nettype none
// ============================================================================
// Timer queue scheduler RAM
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module tqs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/timer_queue_scheduler.sv */
`default_nettype none
// ============================================================================
// Timer queue scheduler
// Table of one-shot and periodic timers with add, delete and advance
// operations; advance fires due timers earliest first and reports the wait.
// ============================================================================
// Delete: the result follows in the cycle after start. Add: a free slot is found
// by the one-slot-per-cycle walk over the live bits.
// Advance: each firing or silent expiry costs one table scan (one RAM read per
// cycle) plus the decide and fire states and, for a periodic timer, the re-arm
// state; the closing scan and the decide state give the done result. Busy for
// the whole item. Results go out one per strobe cycle; the receiver cannot stall
// them. Reset (synchronous) clears live and cancel bits at once and loads the
// register reset values; the timer RAM needs no clearing pass.
// ============================================================================
module timer_queue_scheduler #(
   parameter int TIMERS   = 16,
   parameter int MAX_FIRE = 63
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // command side
   input  wire logic                      start,
   output logic                           busy,
   input  wire tqs_pkg::func_type         req_func,
   input  wire tqs_pkg::time_type         req_time_ms,
   input  wire tqs_pkg::ivl_type          req_interval_ms,
   input  wire tqs_pkg::handle_type       req_handle,
   // result side
   output logic                           rsp_strobe,
   output tqs_pkg::kind_type              rsp_kind,
   output tqs_pkg::handle_type            rsp_slot,
   output tqs_pkg::time_type              rsp_fire_time_ms,
   output tqs_pkg::time_type              rsp_wait_ms,
   output logic                           rsp_last,
   // register write channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire tqs_pkg::csr_index_type    csr_index,
   input  wire tqs_pkg::cfg_type          csr_wdata
);

   import tqs_pkg::*;

   localparam int SLOT_W = $clog2(TIMERS);
   localparam int CNT_W  = $clog2(TIMERS + 1);
   localparam int FIRE_W = $clog2(MAX_FIRE + 1);
   localparam int RAM_W  = TIME_W + IVL_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIMERS);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD    = 3'd1;  // walk live bits for a free slot
   localparam logic [2:0] S_SCAN   = 3'd2;  // find earliest live timer
   localparam logic [2:0] S_DECIDE = 3'd3;  // stop test, done result
   localparam logic [2:0] S_FIRE   = 3'd4;  // lateness test, fire or expire
   localparam logic [2:0] S_REARM  = 3'd5;  // periodic re-arm write

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              found_ff, found_in;
   logic [FIRE_W-1:0] fired_ff, fired_in;
   logic [TIMERS-1:0] live_ff, live_in;
   logic [TIMERS-1:0] canc_ff, canc_in;
   cfg_type           catchup_ff, catchup_in;
   cfg_type           def_wait_ff, def_wait_in;
   cfg_type           min_wait_ff, min_wait_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // payload
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   time_type          best_due_ff, best_due_in;
   ivl_type           best_ivl_ff, best_ivl_in;
   time_type          base_ff, base_in;
   time_type          now_ff, now_in;
   ivl_type           ivl_ff, ivl_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   handle_type        rsp_slot_ff, rsp_slot_in;
   time_type          rsp_fire_ff, rsp_fire_in;
   time_type          rsp_wait_ff, rsp_wait_in;
   logic              rsp_last_ff, rsp_last_in;

   // timer RAM: {due time, repeat interval}
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [RAM_W-1:0]  ram_wr_data;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [RAM_W-1:0]  ram_rd_data;
   time_type          rd_due;
   ivl_type           rd_ivl;

   // shared adder
   time_type          add_a;
   time_type          add_b;
   logic              add_cin;
   logic [TIME_W:0]   add_sum;

   logic [SLOT_W-1:0] cnt_idx;
   logic [SLOT_W-1:0] hidx;
   logic              h_in_range;
   logic              stop;
   logic              late;
   time_type          fire_time;
   time_type          wait_raw;

   tqs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_due = ram_rd_data[RAM_W-1:IVL_W];
   assign rd_ivl = ram_rd_data[IVL_W-1:0];

   // Adder operands per state:
   //   decide: due - now (two's complement add)
   //   fire:   due + catchup limit, for the lateness test
   //   rearm:  fire base + interval, carry out saturates
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         S_DECIDE: begin
            add_a   = best_due_ff;
            add_b   = ~now_ff;
            add_cin = 1'b1;
         end
         S_FIRE: begin
            add_a = best_due_ff;
            add_b = TIME_W'(catchup_ff);
         end
         S_REARM: begin
            add_a = base_ff;
            add_b = TIME_W'(best_ivl_ff);
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (TIME_W + 1)'(add_cin);

   assign cnt_idx    = cnt_ff[SLOT_W-1:0];
   assign hidx       = SLOT_W'(req_handle);
   assign h_in_range = 32'(req_handle) < TIMERS;
   assign stop       = !found_ff || (best_due_ff > now_ff) || (32'(fired_ff) >= MAX_FIRE);
   assign late       = add_sum < {1'b0, now_ff};
   assign fire_time  = late ? now_ff : best_due_ff;
   assign wait_raw   = !found_ff ? TIME_W'(def_wait_ff) :
                       (best_due_ff > now_ff) ? add_sum[TIME_W-1:0] : '0;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = rd_vld_ff;
      found_in      = found_ff;
      fired_in      = fired_ff;
      live_in       = live_ff;
      canc_in       = canc_ff;
      catchup_in    = catchup_ff;
      def_wait_in   = def_wait_ff;
      min_wait_in   = min_wait_ff;
      rsp_strobe_in = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_due_in   = best_due_ff;
      best_ivl_in   = best_ivl_ff;
      base_in       = base_ff;
      now_in        = now_ff;
      ivl_in        = ivl_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fire_in   = rsp_fire_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = best_idx_ff;
      ram_wr_data   = {best_due_ff, best_ivl_ff};
      ram_rd_addr   = cnt_idx;

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_valid) begin
         case (csr_index)
            CSR_CATCHUP:  catchup_in  = csr_wdata;
            CSR_DEF_WAIT: def_wait_in = csr_wdata;
            CSR_MIN_WAIT: min_wait_in = csr_wdata;
            default:      catchup_in  = catchup_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_func)
                  FUNC_ADD: begin
                     now_in   = req_time_ms;
                     ivl_in   = req_interval_ms;
                     cnt_in   = '0;
                     state_in = S_ADD;
                  end
                  FUNC_DELETE: begin
                     if (h_in_range && live_ff[hidx]) begin
                        canc_in[hidx] = 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_DELETED;
                     rsp_slot_in   = req_handle;
                     rsp_fire_in   = '0;
                     rsp_wait_in   = '0;
                     rsp_last_in   = 1'b1;
                  end
                  FUNC_ADVANCE: begin
                     now_in    = req_time_ms;
                     fired_in  = '0;
                     cnt_in    = '0;
                     rd_vld_in = 1'b0;
                     found_in  = 1'b0;
                     state_in  = S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;  // unknown op: no result
                  end
               endcase
            end
         end

         S_ADD: begin
            if (cnt_ff == CNT_LAST) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_FULL;
               rsp_slot_in   = '0;
               rsp_fire_in   = '0;
               rsp_wait_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (!live_ff[cnt_idx]) begin
               live_in[cnt_idx] = 1'b1;
               canc_in[cnt_idx] = 1'b0;
               ram_wr_en        = 1'b1;
               ram_wr_addr      = cnt_idx;
               ram_wr_data      = {now_ff, ivl_ff};
               rsp_strobe_in    = 1'b1;
               rsp_kind_in      = KIND_ADDED;
               rsp_slot_in      = HANDLE_W'(cnt_idx);
               rsp_fire_in      = '0;
               rsp_wait_in      = '0;
               rsp_last_in      = 1'b1;
               state_in         = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         S_SCAN: begin
            // strict less-than keeps the lowest slot on equal due times
            if (rd_vld_ff && live_ff[rd_idx_ff] && (!found_ff || rd_due < best_due_ff)) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_due_in = rd_due;
               best_ivl_in = rd_ivl;
            end
            if (cnt_ff != CNT_LAST) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_idx;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
               if (!rd_vld_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            if (stop) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_DONE;
               rsp_slot_in   = '0;
               rsp_fire_in   = '0;
               rsp_wait_in   = (wait_raw < TIME_W'(min_wait_ff)) ?
                               TIME_W'(min_wait_ff) : wait_raw;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_FIRE;
            end
         end

         S_FIRE: begin
            cnt_in    = '0;
            rd_vld_in = 1'b0;
            found_in  = 1'b0;
            if (canc_ff[best_idx_ff]) begin
               // cancelled: expire without a result
               live_in[best_idx_ff] = 1'b0;
               canc_in[best_idx_ff] = 1'b0;
               state_in             = S_SCAN;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_FIRED;
               rsp_slot_in   = HANDLE_W'(best_idx_ff);
               rsp_fire_in   = fire_time;
               rsp_wait_in   = '0;
               rsp_last_in   = 1'b0;
               fired_in      = fired_ff + FIRE_W'(1);
               if (best_ivl_ff == '0) begin
                  live_in[best_idx_ff] = 1'b0;
                  state_in             = S_SCAN;
               end else begin
                  base_in  = fire_time;
                  state_in = S_REARM;
               end
            end
         end

         S_REARM: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = best_idx_ff;
            ram_wr_data = {(add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0]),
                           best_ivl_ff};
            cnt_in      = '0;
            rd_vld_in   = 1'b0;
            found_in    = 1'b0;
            state_in    = S_SCAN;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         fired_ff      <= '0;
         live_ff       <= '0;
         canc_ff       <= '0;
         catchup_ff    <= CATCHUP_RESET;
         def_wait_ff   <= DEF_WAIT_RESET;
         min_wait_ff   <= MIN_WAIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         fired_ff      <= fired_in;
         live_ff       <= live_in;
         canc_ff       <= canc_in;
         catchup_ff    <= catchup_in;
         def_wait_ff   <= def_wait_in;
         min_wait_ff   <= min_wait_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_due_ff <= best_due_in;
      best_ivl_ff <= best_ivl_in;
      base_ff     <= base_in;
      now_ff      <= now_in;
      ivl_ff      <= ivl_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_fire_ff <= rsp_fire_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_fire_time_ms = rsp_fire_ff;
   assign rsp_wait_ms      = rsp_wait_ff;
   assign rsp_last         = rsp_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // only firings are followed by further results of the same item
   a_nonlast_is_fire: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_kind == KIND_FIRED))
      else $error("non-final result that is not a firing");

   // firing count never passes the per-advance limit
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      (32'(fired_ff) <= MAX_FIRE))
      else $error("firing count above limit");

   // a delete transfer answers in the next cycle and stays idle
   a_delete_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_DELETE) |=>
         (rsp_strobe && rsp_kind == KIND_DELETED && rsp_last && !busy))
      else $error("delete result missing");

   // a firing result is only produced while an advance is still running
   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == KIND_FIRED) |-> busy)
      else $error("firing result outside an advance");

endmodule
`default_nettype wire

/* bench/timer_queue_scheduler_scoreboard.sv */
// ============================================================================
// Timer queue scheduler scoreboard
// Mirrors the timer table from the command and register transfers it sees,
// predicts the result transfers of each command and checks them in order.
// ============================================================================
module timer_queue_scheduler_scoreboard #(
   parameter int TIMERS   = 16,
   parameter int MAX_FIRE = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  tqs_pkg::func_type      req_func,
   input  tqs_pkg::time_type      req_time_ms,
   input  tqs_pkg::ivl_type       req_interval_ms,
   input  tqs_pkg::handle_type    req_handle,
   input  logic                   rsp_strobe,
   input  tqs_pkg::kind_type      rsp_kind,
   input  tqs_pkg::handle_type    rsp_slot,
   input  tqs_pkg::time_type      rsp_fire_time_ms,
   input  tqs_pkg::time_type      rsp_wait_ms,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  tqs_pkg::csr_index_type csr_index,
   input  tqs_pkg::cfg_type       csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import tqs_pkg::*;

   typedef struct packed {
      kind_type   kind;
      handle_type slot;
      time_type   fire_time_ms;
      time_type   wait_ms;
      logic       last;
   } timer_event_type;

   timer_event_type timer_events[$];

   cfg_type  catchup_ms;
   cfg_type  def_wait_ms;
   cfg_type  floor_ms;
   time_type due_ms    [TIMERS];
   ivl_type  period_ms [TIMERS];
   logic     armed     [TIMERS];
   logic     cancelled [TIMERS];

   int error_total = 0;
   int queued      = 0;
   int result_seq  = 0;

   assign mismatches  = error_total;
   assign outstanding = queued;

   task automatic log_mismatch(string note);
      error_total++;
      $display("[%0t] result %0d: %s", $time, result_seq, note);
   endtask

   function automatic void push_event(kind_type kind, handle_type slot, time_type fire_ms,
                                      time_type gap_ms, logic last);
      timer_event_type ev;
      ev.kind         = kind;
      ev.slot         = slot;
      ev.fire_time_ms = fire_ms;
      ev.wait_ms      = gap_ms;
      ev.last         = last;
      timer_events.push_back(ev);
   endfunction

   // lowest index wins ties
   function automatic int earliest_slot();
      int best;
      int i;
      best = -1;
      for (i = 0; i < TIMERS; i++)
         if (armed[i] && (best < 0 || due_ms[i] < due_ms[best]))
            best = i;
      return best;
   endfunction

   function automatic void apply_timer_op(func_type func, time_type now, ivl_type ivl,
                                          handle_type h);
      int              s;
      int              i;
      int              fired;
      logic            late;
      time_type        base;
      time_type        gap_ms;
      logic [TIME_W:0] next_due;
      case (func)
         FUNC_ADD: begin
            s = -1;
            for (i = TIMERS - 1; i >= 0; i--)
               if (!armed[i])
                  s = i;
            if (s < 0)
               push_event(KIND_FULL, '0, '0, '0, 1'b1);
            else begin
               armed[s]     = 1'b1;
               cancelled[s] = 1'b0;
               due_ms[s]    = now;
               period_ms[s] = ivl;
               push_event(KIND_ADDED, handle_type'(s), '0, '0, 1'b1);
            end
         end
         FUNC_DELETE: begin
            if (int'(h) < TIMERS && armed[h])
               cancelled[h] = 1'b1;
            push_event(KIND_DELETED, h, '0, '0, 1'b1);
         end
         FUNC_ADVANCE: begin
            fired = 0;
            s = earliest_slot();
            while (s >= 0 && due_ms[s] <= now && fired < MAX_FIRE) begin
               late = ({1'b0, due_ms[s]} + catchup_ms) < {1'b0, now};
               base = late ? now : due_ms[s];
               if (cancelled[s]) begin
                  // cancelled timers expire silently and free the slot
                  armed[s]     = 1'b0;
                  cancelled[s] = 1'b0;
               end else begin
                  push_event(KIND_FIRED, handle_type'(s), base, '0, 1'b0);
                  fired++;
                  if (period_ms[s] == '0)
                     armed[s] = 1'b0;
                  else begin
                     next_due  = {1'b0, base} + period_ms[s];
                     due_ms[s] = next_due[TIME_W] ? '1 : next_due[TIME_W-1:0];
                  end
               end
               s = earliest_slot();
            end
            if (s < 0)
               gap_ms = time_type'(def_wait_ms);
            else if (due_ms[s] > now)
               gap_ms = due_ms[s] - now;
            else
               gap_ms = '0;
            if (gap_ms < time_type'(floor_ms))
               gap_ms = time_type'(floor_ms);
            push_event(KIND_DONE, '0, '0, gap_ms, 1'b1);
         end
         default: ;  // unknown operation: no effect, no result
      endcase
   endfunction

   always @(posedge clock) begin
      timer_event_type ev;
      int              i;
      if (reset) begin
         catchup_ms  = CATCHUP_RESET;
         def_wait_ms = DEF_WAIT_RESET;
         floor_ms    = MIN_WAIT_RESET;
         for (i = 0; i < TIMERS; i++) begin
            armed[i]     = 1'b0;
            cancelled[i] = 1'b0;
         end
         timer_events.delete();
      end else begin
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_CATCHUP:  catchup_ms  = csr_wdata;
               CSR_DEF_WAIT: def_wait_ms = csr_wdata;
               CSR_MIN_WAIT: floor_ms    = csr_wdata;
               default: ;
            endcase
         end
         if (start === 1'b1 && busy === 1'b0)
            apply_timer_op(req_func, req_time_ms, req_interval_ms, req_handle);
         if (rsp_strobe === 1'b1) begin
            if (timer_events.size() == 0)
               log_mismatch($sformatf("kind %0d with no result pending", rsp_kind));
            else begin
               ev = timer_events.pop_front();
               if (rsp_kind !== ev.kind)
                  log_mismatch($sformatf("kind %0d, want %0d", rsp_kind, ev.kind));
               if (rsp_slot !== ev.slot)
                  log_mismatch($sformatf("slot %0d, want %0d", rsp_slot, ev.slot));
               if (rsp_fire_time_ms !== ev.fire_time_ms)
                  log_mismatch($sformatf("fire time 0x%0h, want 0x%0h",
                                         rsp_fire_time_ms, ev.fire_time_ms));
               if (rsp_wait_ms !== ev.wait_ms)
                  log_mismatch($sformatf("wait 0x%0h, want 0x%0h", rsp_wait_ms, ev.wait_ms));
               if (rsp_last !== ev.last)
                  log_mismatch($sformatf("last %0b, want %0b", rsp_last, ev.last));
            end
            result_seq++;
         end
      end
      queued <= timer_events.size();
   end

endmodule

/* bench/timer_queue_scheduler_test.sv */
// ============================================================================
// Timer queue scheduler testbench
// Drives add, delete and advance commands plus register writes into the
// scheduler; the scoreboard beside it predicts and checks every result.
// ============================================================================
module timer_queue_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tqs_pkg::*;

   localparam int TIMERS   = 16;
   localparam int MAX_FIRE = 63;

   // codes the package leaves unnamed
   localparam func_type      FUNC_UNKNOWN = 2'd3;
   localparam csr_index_type CSR_UNUSED   = 2'd3;

   localparam time_type TIME_MAX = '1;
   localparam ivl_type  IVL_MAX  = '1;

   // quiet cycles after the table has drained: covers an add walk or an
   // unknown command still in flight with margin
   localparam int SETTLE_CYCLES  = 2 * (TIMERS + 4);
   // worst quiet stretch is an advance freeing every slot silently before its
   // first result (about TIMERS scans, each with its decide and fire states); allow
   // well over ten times that
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 110;

   logic          clock           = 1'b0;
   logic          reset           = 1'b1;
   logic          start           = 1'b0;
   logic          busy;
   func_type      req_func        = FUNC_ADD;
   time_type      req_time_ms     = '0;
   ivl_type       req_interval_ms = '0;
   handle_type    req_handle      = '0;
   logic          rsp_strobe;
   kind_type      rsp_kind;
   handle_type    rsp_slot;
   time_type      rsp_fire_time_ms;
   time_type      rsp_wait_ms;
   logic          rsp_last;
   logic          csr_valid       = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index       = CSR_CATCHUP;
   cfg_type       csr_wdata       = '0;

   int       mismatch_count;
   int       results_pending;
   int       idle_pct     = 0;
   int       stall_cycles = 0;
   time_type now_ms       = '0;

   timer_queue_scheduler #(
      .TIMERS   (TIMERS),
      .MAX_FIRE (MAX_FIRE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_time_ms      (req_time_ms),
      .req_interval_ms  (req_interval_ms),
      .req_handle       (req_handle),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_fire_time_ms (rsp_fire_time_ms),
      .rsp_wait_ms      (rsp_wait_ms),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   timer_queue_scheduler_scoreboard #(
      .TIMERS   (TIMERS),
      .MAX_FIRE (MAX_FIRE)
   ) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_time_ms      (req_time_ms),
      .req_interval_ms  (req_interval_ms),
      .req_handle       (req_handle),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_fire_time_ms (rsp_fire_time_ms),
      .rsp_wait_ms      (rsp_wait_ms),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatch_count),
      .outstanding      (results_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: any command, result or register transfer clears the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic time_type any_time();
      return time_type'({$urandom, $urandom});
   endfunction

   // mostly one-shot, then short periods, a few full-width ones
   function automatic ivl_type pick_period();
      int roll;
      roll = $urandom_range(9);
      if (roll < 5)
         return '0;
      if (roll < 9)
         return ivl_type'($urandom_range(1, 150));
      return ivl_type'($urandom);
   endfunction

   // One command transfer. Random idle cycles first, then start stays high
   // until the edge where busy is low. start is left high afterwards: the
   // next call either drops it or reuses it, so it never sees two updates in
   // one step.
   task automatic issue(func_type func, time_type t, ivl_type ivl, handle_type h);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_func        <= func;
      req_time_ms     <= t;
      req_interval_ms <= ivl;
      req_handle      <= h;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Hold off until every predicted result has come out.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (results_pending != 0 || busy !== 1'b0);
   endtask

   // Drain, then let any result-free command finish before touching registers.
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; program_regs drops it.
   task automatic write_reg(csr_index_type idx, cfg_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic program_regs(cfg_type catchup, cfg_type def_wait, cfg_type min_wait);
      write_reg(CSR_CATCHUP, catchup);
      write_reg(CSR_DEF_WAIT, def_wait);
      write_reg(CSR_MIN_WAIT, min_wait);
      csr_valid <= 1'b0;
   endtask

   // Cancel every slot, then advance to the end of time: every timer
   // expires silently and the table starts the phase empty.
   task automatic flush_table();
      int k;
      for (k = 0; k < TIMERS; k++)
         issue(FUNC_DELETE, any_time(), ivl_type'($urandom), handle_type'(k));
      issue(FUNC_ADVANCE, TIME_MAX, ivl_type'($urandom), handle_type'($urandom));
   endtask

   // Mostly well-formed traffic around a moving current time; a few far
   // jumps, wild due times, pauses and unknown commands mixed in.
   task automatic random_burst(int count);
      int  sent;
      int  roll;
      bit  counted;
      sent   = 0;
      now_ms = time_type'($urandom_range(0, 100000));
      while (sent < count) begin
         roll    = $urandom_range(99);
         counted = 1'b1;
         if (roll < 35)
            issue(FUNC_ADD, now_ms + time_type'($urandom_range(0, 400)), pick_period(),
                  handle_type'($urandom));
         else if (roll < 37)
            issue(FUNC_ADD, any_time(), pick_period(), handle_type'($urandom));
         else if (roll < 49)
            issue(FUNC_DELETE, any_time(), ivl_type'($urandom), handle_type'($urandom));
         else if (roll < 91) begin
            // occasional long gap so timers fall behind the catch-up limit
            if ($urandom_range(9) == 0)
               now_ms += time_type'($urandom_range(1000, 80000));
            else
               now_ms += time_type'($urandom_range(0, 250));
            issue(FUNC_ADVANCE, now_ms, ivl_type'($urandom), handle_type'($urandom));
         end else if (roll < 94)
            issue(FUNC_ADVANCE, any_time(), ivl_type'($urandom), handle_type'($urandom));
         else if (roll < 96) begin
            drain();
            counted = 1'b0;
         end else begin
            issue(FUNC_UNKNOWN, any_time(), ivl_type'($urandom), handle_type'($urandom));
            counted = 1'b0;
         end
         if (counted)
            sent++;
      end
   endtask

   initial begin
      int k;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, register reset values ----
      idle_pct = 24;
      // empty table: default wait
      issue(FUNC_ADVANCE, '0, '0, '0);
      // one-shot and periodic tie at the same due time
      issue(FUNC_ADD, 40'd5, '0, '0);
      issue(FUNC_ADD, 40'd5, 24'd3, '0);
      // slot 2 gets cancelled and must expire silently
      issue(FUNC_ADD, 40'd100, '0, '0);
      // near the top of time with the widest period: re-arm saturates
      issue(FUNC_ADD, TIME_MAX - 40'd3, IVL_MAX, '1);
      // fires every millisecond: drives an advance into the firing limit
      issue(FUNC_ADD, 40'd10, 24'd1, '0);
      for (k = 5; k < TIMERS; k++)
         issue(FUNC_ADD, time_type'(40 + k), '0, '0);
      // table full: refused
      issue(FUNC_ADD, any_time(), ivl_type'($urandom), '0);
      issue(FUNC_DELETE, '0, '0, handle_type'(2));
      issue(FUNC_DELETE, '0, '0, '1);
      // firing limit hit with timers still due: wait floors at the minimum
      issue(FUNC_ADVANCE, 40'd80, '0, '0);
      // everyone far behind the catch-up limit: fire at now, re-arm from now
      issue(FUNC_ADVANCE, 40'd3000, '0, '0);
      // end of time: periodic timers pin at the saturated due time
      issue(FUNC_ADVANCE, TIME_MAX, IVL_MAX, '1);
      // delete of a slot that is no longer live
      issue(FUNC_DELETE, TIME_MAX, IVL_MAX, '0);
      issue(FUNC_UNKNOWN, TIME_MAX, IVL_MAX, '1);

      // ---- random phase 1: low register extremes ----
      settle();
      program_regs('0, '0, '0);
      flush_table();
      random_burst(PHASE_ITEMS);

      // ---- random phase 2: high register extremes, slow sender ----
      settle();
      program_regs('1, '1, '1);
      idle_pct = 86;
      flush_table();
      random_burst(PHASE_ITEMS);

      // ---- random phase 3: random registers, back-to-back commands ----
      settle();
      // the unused index must not disturb any register
      write_reg(CSR_UNUSED, cfg_type'($urandom));
      program_regs(cfg_type'($urandom_range(0, 3000)), cfg_type'($urandom),
                   cfg_type'($urandom_range(0, 60)));
      idle_pct = 0;
      flush_table();
      random_burst(PHASE_ITEMS);

      settle();
      if (mismatch_count == 0 && results_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
